// ----- design/circular_queue_with_search_defines.svh -----
// Assertion macros shared by the circular queue with search.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cqs_pkg.sv -----
// Package for the circular queue with search: sizes, codes, payload types
// and slot arithmetic. Used by the top level.
`timescale 1ns / 1ps

package cqs_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_SRCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [2:0]         slot_found;
  } res_t;

  // Slot that lies off places after base, wrapped into the ring.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // The reported slot keeps only the low three bits of the slot index.
  function automatic logic [2:0] slot_out(logic [AW-1:0] s);
    logic [AW+2:0] ext;
    ext = (AW+3)'(s);
    return ext[2:0];
  endfunction

endpackage

// ----- design/cqs_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
// Holds the queue entries; no reset on the storage.
`timescale 1ns / 1ps

module cqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/circular_queue_with_search.sv -----
// Circular queue with search. Enqueue and error results are registered and
// appear in the cycle after the request is taken; a dequeue does one RAM read
// and then waits in S_DEQ for the output register. A search reads one entry per
// cycle from the RAM port, oldest first, until the match or the newest entry.
// One request at a time: the next request is taken the cycle after its result
// is loaded, unless stalled. Reset clears state, head, occupancy, scan index and
// the output valid flag; entries are not cleared and are only read once written.
`timescale 1ns / 1ps

module circular_queue_with_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cqs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cqs_pkg::res_t out_res_o
);

  `include "circular_queue_with_search_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SEARCH
  } state_e;

  state_e                    state_q, state_d;
  logic [cqs_pkg::AW-1:0]    head_q, head_d;
  logic [cqs_pkg::CW-1:0]    occ_q, occ_d;
  logic [cqs_pkg::AW-1:0]    cmp_q, cmp_d;
  logic [cqs_pkg::DW-1:0]    key_q, key_d;
  logic                      out_valid_q, out_valid_d;
  cqs_pkg::res_t             out_res_q, out_res_d;

  logic                      we;
  logic [cqs_pkg::AW-1:0]    waddr;
  logic                      re;
  logic [cqs_pkg::AW-1:0]    raddr;
  logic [cqs_pkg::DW-1:0]    rdata;

  logic                      out_free;
  logic                      in_acc;
  logic                      hit;
  logic                      last;
  logic [cqs_pkg::CW-1:0]    scan_pos;
  logic [cqs_pkg::CW-1:0]    occ_inc;
  logic                      enq_take;

  cqs_ram #(
    .WIDTH(cqs_pkg::DW),
    .DEPTH(cqs_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_req_i.value),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The output register can take a result when it is empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign scan_pos = cqs_pkg::CW'(cmp_q);
  assign occ_inc  = occ_q + cqs_pkg::CW'(1);
  assign enq_take = in_acc && (in_req_i.req_type == cqs_pkg::REQ_ENQ)
                  && (occ_q != cqs_pkg::CW'(cqs_pkg::DEPTH));

  assign hit  = (rdata == key_q);
  assign last = ((scan_pos + cqs_pkg::CW'(1)) == occ_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    occ_d       = occ_q;
    cmp_d       = cmp_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    we          = 1'b0;
    waddr       = cqs_pkg::wrap_add(head_q, occ_q);
    re          = 1'b0;
    raddr       = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_res_d = '{status: cqs_pkg::ST_OK, data_out: '0, slot_found: '0};
          unique case (in_req_i.req_type)
            cqs_pkg::REQ_ENQ: begin
              out_valid_d = 1'b1;
              if (occ_q == cqs_pkg::CW'(cqs_pkg::DEPTH)) begin
                out_res_d.status = cqs_pkg::ST_FULL;
              end else begin
                we    = 1'b1;
                occ_d = occ_q + cqs_pkg::CW'(1);
              end
            end
            cqs_pkg::REQ_DEQ: begin
              if (occ_q == '0) begin
                out_valid_d      = 1'b1;
                out_res_d.status = cqs_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                occ_d   = occ_q - cqs_pkg::CW'(1);
                head_d  = (occ_q == cqs_pkg::CW'(1)) ? '0
                        : cqs_pkg::wrap_add(head_q, cqs_pkg::CW'(1));
                state_d = S_DEQ;
              end
            end
            cqs_pkg::REQ_SRCH: begin
              if (occ_q == '0) begin
                out_valid_d      = 1'b1;
                out_res_d.status = cqs_pkg::ST_EMPTY;
              end else begin
                re      = 1'b1;
                key_d   = in_req_i.value;
                cmp_d   = '0;
                state_d = S_SEARCH;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_DEQ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = '{status: cqs_pkg::ST_OK, data_out: $signed(rdata), slot_found: '0};
          state_d     = S_IDLE;
        end
      end

      S_SEARCH: begin
        // rdata holds entry cmp_q; the read of the next entry is issued while it is checked.
        if (hit || last) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_res_d   = '{status: hit ? cqs_pkg::ST_OK : cqs_pkg::ST_NOTFOUND,
                            data_out: '0,
                            slot_found: hit ? cqs_pkg::slot_out(
                              cqs_pkg::wrap_add(head_q, cqs_pkg::CW'(cmp_q))) : 3'd0};
            state_d     = S_IDLE;
          end
        end else begin
          re    = 1'b1;
          raddr = cqs_pkg::wrap_add(head_q, cqs_pkg::CW'(cmp_q) + cqs_pkg::CW'(1));
          cmp_d = cmp_q + cqs_pkg::AW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      cmp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      cmp_q       <= cmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `CQS_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= cqs_pkg::CW'(cqs_pkg::DEPTH), "queue overfilled")
  `CQS_ASSERT_NOW(a_scan_range, state_q == S_SEARCH, scan_pos < occ_q, "scan past newest entry")
  `CQS_ASSERT_NOW(a_take_idle, !in_stall_o, state_q == S_IDLE, "request taken while busy")
  `CQS_ASSERT_NEXT(a_enq_grow, enq_take, occ_q == $past(occ_inc), "enqueue did not grow queue")

endmodule
